@@ src/sis_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sis_pkg
// shared constants and types of the stable insertion sorter
// ---------------------------------------------------------------------------
package sis_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage
`default_nettype wire

@@ src/sis_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sis_cell
// one slot of the sorted chain: compares against the new key, takes the key
// or its left neighbor's value on insert and its right neighbor's on unload
// ---------------------------------------------------------------------------
module sis_cell
(
    input  wire logic                          clk,
    input  wire sis_pkg::cell_ctrl_t           ctrl,
    input  wire logic                          occupied,
    input  wire logic signed [sis_pkg::VALUE_W-1:0] key,
    input  wire logic                          prev_take,
    input  wire logic signed [sis_pkg::VALUE_W-1:0] prev_value,
    input  wire logic signed [sis_pkg::VALUE_W-1:0] next_value,
    output logic                               take,
    output logic signed [sis_pkg::VALUE_W-1:0] value
);

    logic signed [sis_pkg::VALUE_W-1:0] value_reg;
    logic signed [sis_pkg::VALUE_W-1:0] value_next;

    // strictly greater keeps equal entries ahead of the new one
    assign take  = !occupied || (value_reg > key);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert && take)
        begin
            value_next = prev_take ? prev_value : key;
        end
        else if (ctrl.shift)
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule
`default_nettype wire

@@ src/stable_insertion_sorter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stable_insertion_sorter
// stable ascending sort of signed 32-bit batches in a chain of cells
// ---------------------------------------------------------------------------
// Values stream in on the slave side, one request per cycle, and each is
// inserted on acceptance into a chain of DEPTH cells that compare against
// it in parallel; equal values keep arrival order. Values arriving with the
// chain full are dropped and flag overflow on the batch. The request marked
// tlast closes the batch: the chain then unloads from its head, one result
// per cycle that the master side accepts, tlast on the final one, and the
// slave side is held off until the batch has left. A batch of n values thus
// unloads as min(n, DEPTH) results, paced by the single output port at the
// head of the chain.
// ---------------------------------------------------------------------------
module stable_insertion_sorter
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic        s_axis_tlast,   // is_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] sorted_value
    output logic             m_axis_tlast,   // last_out
    output logic             m_axis_tuser    // overflow
);

    localparam int D = sis_pkg::DEPTH;
    localparam int W = sis_pkg::VALUE_W;
    localparam int C = sis_pkg::CNT_W;

    typedef enum logic { FILL, DRAIN } state_t;

    state_t          state_reg, state_next;
    logic [C-1:0]    count_reg, count_next;
    logic            flag_reg, flag_next;

    logic            in_acc, out_acc, full;
    sis_pkg::cell_ctrl_t ctrl;

    logic [D-1:0]          occ;
    logic [D-1:0]          take;
    logic signed [W-1:0]   cell_value [D];
    logic signed [W-1:0]   key;

    assign key           = $signed(s_axis_tdata);
    assign full          = (count_reg == C'(D));
    assign s_axis_tready = (state_reg == FILL);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == DRAIN);
    assign out_acc       = m_axis_tvalid && m_axis_tready;

    assign ctrl.insert = in_acc && !full;
    assign ctrl.shift  = out_acc;

    assign m_axis_tdata = cell_value[0];
    assign m_axis_tlast = (count_reg == C'(1));
    assign m_axis_tuser = flag_reg;

    genvar g;
    generate
        for (g = 0; g < D; g++)
        begin : g_cell
            logic                prev_take;
            logic signed [W-1:0] prev_value;
            logic signed [W-1:0] next_value;

            assign occ[g] = (C'(g) < count_reg);

            if (g == 0)
            begin : g_head
                assign prev_take  = 1'b0;
                assign prev_value = key;
            end
            else
            begin : g_body
                assign prev_take  = take[g-1];
                assign prev_value = cell_value[g-1];
            end

            if (g == D - 1)
            begin : g_tail
                assign next_value = cell_value[g];
            end
            else
            begin : g_inner
                assign next_value = cell_value[g+1];
            end

            sis_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occ[g]),
                .key        (key),
                .prev_take  (prev_take),
                .prev_value (prev_value),
                .next_value (next_value),
                .take       (take[g]),
                .value      (cell_value[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        flag_next  = flag_reg;
        case (state_reg)
            FILL:
            begin
                if (in_acc)
                begin
                    if (full)
                    begin
                        flag_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + C'(1);
                    end
                    if (s_axis_tlast)
                    begin
                        state_next = DRAIN;
                    end
                end
            end
            DRAIN:
            begin
                if (out_acc)
                begin
                    count_next = count_reg - C'(1);
                    // batch done once the tail result leaves
                    if (count_reg == C'(1))
                    begin
                        state_next = FILL;
                        flag_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FILL;
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

endmodule
`default_nettype wire
